// File: rtl/sfc_pkg.sv
// Package for the sphere/frustum cull core: widths, request codes and the
// front-to-back queue entry type. No dependencies.
package sfc_pkg;
  localparam int NumPlanesDef = 6;
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqTest = 1'b1;
  localparam int SqrtSteps = 32;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    logic [63:0]        s;
  } sfc_item_t;
endpackage

// File: rtl/sphere_frustum_cull_core.sv
// Sphere/frustum cull core: a load item writes one of NUM_PLANES planes and gives
// no result; a test item gives one visibility beat. A test is squared in the front
// stage, queued, then the back part runs a bit-serial square root and a multiply
// state and a compare state per plane, stopping at the first rejecting plane. The
// front stage and a two-entry queue hold up to three tests ahead of the back part.
// A load is held off until every earlier test has left the back part. Planes are
// zero at reset.
module sphere_frustum_cull_core import sfc_pkg::*; #(
  parameter int NUM_PLANES = NumPlanesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_req_type,
  input  logic [2:0]        in_plane_index,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic signed [31:0] in_plane_offset,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_min_z,
  input  logic [30:0]       in_box_ext_x,
  input  logic [30:0]       in_box_ext_y,
  input  logic [30:0]       in_box_ext_z,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_visible
);
  logic [NUM_PLANES-1:0][47:0] pl_norm;
  logic [NUM_PLANES-1:0][31:0] pl_off;
  logic q_push, q_full, q_pop, q_empty;
  logic back_busy, tests_pend;
  sfc_item_t q_din, q_dout;

  assign tests_pend = !q_empty || back_busy;

  sfc_front #(.NUM_PLANES(NUM_PLANES)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_plane_index,
    .in_normal_x, .in_normal_y, .in_normal_z, .in_plane_offset,
    .in_box_min_x, .in_box_min_y, .in_box_min_z,
    .in_box_ext_x, .in_box_ext_y, .in_box_ext_z, .tests_pend,
    .pl_norm, .pl_off, .q_push, .q_data(q_din), .q_full);

  sfc_queue #(.DEPTH(QueueDepth)) u_queue (
    .clk, .rst_n, .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty));

  sfc_back #(.NUM_PLANES(NUM_PLANES)) u_back (
    .clk, .rst_n, .q_empty, .q_data(q_dout), .q_pop, .busy(back_busy),
    .pl_norm, .pl_off, .out_empty, .out_pop, .out_visible);
endmodule

// File: rtl/sfc_front.sv
// Front part: takes items, writes planes, forms doubled centre and extent
// sum of squares for tests. Depends on sfc_pkg.
module sfc_front import sfc_pkg::*; #(
  parameter int NUM_PLANES = NumPlanesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_req_type,
  input  logic [2:0]        in_plane_index,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic signed [31:0] in_plane_offset,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_min_z,
  input  logic [30:0]       in_box_ext_x,
  input  logic [30:0]       in_box_ext_y,
  input  logic [30:0]       in_box_ext_z,
  input  logic              tests_pend,
  output logic [NUM_PLANES-1:0][47:0] pl_norm,
  output logic [NUM_PLANES-1:0][31:0] pl_off,
  output logic              q_push,
  output sfc_item_t         q_data,
  input  logic              q_full
);
  logic [NUM_PLANES-1:0][47:0] norm_r;
  logic [NUM_PLANES-1:0][31:0] off_r;
  logic       v1_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [61:0] sx_r, sy_r, sz_r;
  logic acc;

  // hold a load until every earlier test has cleared the back part
  assign in_full = (v1_r && q_full) ||
                   (in_req_type == ReqLoad && (v1_r || tests_pend));
  assign acc = in_push && !in_full;
  assign pl_norm = norm_r;
  assign pl_off  = off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r <= '0;
      off_r  <= '0;
      v1_r   <= 1'b0;
    end else begin
      if (v1_r && !q_full) v1_r <= 1'b0;
      if (acc) begin
        if (in_req_type == ReqLoad) begin
          for (int i = 0; i < NUM_PLANES; i++) begin
            if (in_plane_index == 3'(i)) begin
              norm_r[i] <= {in_normal_z, in_normal_y, in_normal_x};
              off_r[i]  <= in_plane_offset;
            end
          end
        end else begin
          v1_r <= 1'b1;
        end
      end
    end
  end

  // Stage: one 31x31 square per axis, centre doubled.
  always_ff @(posedge clk) begin
    if (acc && in_req_type == ReqTest) begin
      cx_r <= {in_box_min_x[31], in_box_min_x, 1'b0} + 34'({3'b0, in_box_ext_x});
      cy_r <= {in_box_min_y[31], in_box_min_y, 1'b0} + 34'({3'b0, in_box_ext_y});
      cz_r <= {in_box_min_z[31], in_box_min_z, 1'b0} + 34'({3'b0, in_box_ext_z});
      sx_r <= 62'(in_box_ext_x) * 62'(in_box_ext_x);
      sy_r <= 62'(in_box_ext_y) * 62'(in_box_ext_y);
      sz_r <= 62'(in_box_ext_z) * 62'(in_box_ext_z);
    end
  end

  assign q_push    = v1_r && !q_full;
  assign q_data.cx = cx_r;
  assign q_data.cy = cy_r;
  assign q_data.cz = cz_r;
  assign q_data.s  = 64'(sx_r) + 64'(sy_r) + 64'(sz_r);
endmodule

// File: rtl/sfc_queue.sv
// Short queue between front and back parts. Depends on sfc_pkg.
module sfc_queue import sfc_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sfc_item_t din,
  output logic      full,
  input  logic      pop,
  output sfc_item_t dout,
  output logic      empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  sfc_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  assign full  = cnt_r == (AW+1)'(DEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (!(push && full)) else $error("queue overflow");
      assert (!(pop && empty)) else $error("queue underflow");
    end
  end
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("count beyond depth");
endmodule

// File: rtl/sfc_back.sv
// Back part: iterative square root, then the planes one at a time against the
// centre, result held in an output register; a new item is taken only when idle. Depends on sfc_pkg.
module sfc_back import sfc_pkg::*; #(
  parameter int NUM_PLANES = NumPlanesDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  sfc_item_t q_data,
  output logic      q_pop,
  output logic      busy,
  input  logic [NUM_PLANES-1:0][47:0] pl_norm,
  input  logic [NUM_PLANES-1:0][31:0] pl_off,
  output logic      out_empty,
  input  logic      out_pop,
  output logic      out_visible
);
  localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam logic [1:0] StIdle = 2'd0, StSqrt = 2'd1, StMul = 2'd2, StCmp = 2'd3;

  logic [1:0] st_r;
  logic [63:0] op_r, res_r, bit_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [5:0] step_r;
  logic [PW-1:0] pi_r;
  logic signed [49:0] px_r, py_r, pz_r;
  logic signed [48:0] po_r;
  logic vis_r, ov_r;
  logic [63:0] trial;
  logic signed [52:0] plane_dist, lim;
  logic [47:0] nsel;

  assign trial = res_r + bit_r;
  assign q_pop = (st_r == StIdle) && !q_empty && !ov_r;
  assign busy = st_r != StIdle;
  assign out_empty = !ov_r;
  assign out_visible = vis_r;
  assign nsel = pl_norm[pi_r];
  assign plane_dist = 53'(px_r) + 53'(py_r) + 53'(pz_r) + 53'(po_r);
  assign lim  = $signed({1'b0, res_r[36:0], 15'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_pop) ov_r <= 1'b0;
      case (st_r)
        StIdle: if (q_pop) begin
          op_r <= q_data.s; res_r <= '0; bit_r <= 64'h4000_0000_0000_0000;
          cx_r <= q_data.cx; cy_r <= q_data.cy; cz_r <= q_data.cz;
          step_r <= '0; st_r <= StSqrt;
        end
        StSqrt: begin
          // one result bit per cycle
          if (op_r >= trial) begin
            op_r <= op_r - trial; res_r <= (res_r >> 1) + bit_r;
          end else res_r <= res_r >> 1;
          bit_r <= bit_r >> 2;
          step_r <= step_r + 1'b1;
          if (step_r == 6'(SqrtSteps-1)) begin
            st_r <= StMul; pi_r <= '0; vis_r <= 1'b1;
          end
        end
        StMul: begin
          px_r <= cx_r * $signed(nsel[15:0]);
          py_r <= cy_r * $signed(nsel[31:16]);
          pz_r <= cz_r * $signed(nsel[47:32]);
          po_r <= 49'($signed(pl_off[pi_r])) <<< 16;
          st_r <= StCmp;
        end
        default: begin
          if (plane_dist >= lim) begin
            vis_r <= 1'b0; ov_r <= 1'b1; st_r <= StIdle;
          end else if (pi_r == PW'(NUM_PLANES-1)) begin
            ov_r <= 1'b1; st_r <= StIdle;
          end else begin
            pi_r <= pi_r + 1'b1; st_r <= StMul;
          end
        end
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_r == StSqrt) else $error("pop without start");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_pop) |=> ov_r && $stable(vis_r)) else $error("result lost");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !q_pop) else $error("pop while result waits");
endmodule

// File: sim/testbench.sv
// Testbench for sphere_frustum_cull_core: drives plane loads and box tests,
// predicts each visibility result and checks it. Depends on rtl/sfc_pkg.sv and the core.
module testbench;
  import sfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLANES    = NumPlanesDef;
  localparam int STALL_MAX = 5000;
  localparam int LATENCY   = 80;

  logic clk, rst_n;
  logic in_push, in_full, in_req_type;
  logic [2:0] in_plane_index;
  logic signed [15:0] in_normal_x, in_normal_y, in_normal_z;
  logic signed [31:0] in_plane_offset, in_box_min_x, in_box_min_y, in_box_min_z;
  logic [30:0] in_box_ext_x, in_box_ext_y, in_box_ext_z;
  logic out_empty, out_pop, out_visible;

  sphere_frustum_cull_core u_dut (.*);

  // predictor copy of the plane store
  logic signed [15:0] nx_mem [PLANES];
  logic signed [15:0] ny_mem [PLANES];
  logic signed [15:0] nz_mem [PLANES];
  logic signed [31:0] off_mem [PLANES];

  logic visible_q [$];
  int   send_mode, recv_stall;
  bit   hold_req;
  int   n_tests, n_loads, n_culled, n_errors, idle_cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned op);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > op) bit_v >>= 2;
    while (bit_v != 0) begin
      if (op >= res + bit_v) begin
        op -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic box_visible(logic signed [31:0] mx, my, mz,
                                       logic [30:0] ex, ey, ez);
    longint cx, cy, cz, d, lim;
    longint unsigned ux, uy, uz, s;
    ux = ex; uy = ey; uz = ez;
    cx = longint'(mx) * 2 + longint'(ux);
    cy = longint'(my) * 2 + longint'(uy);
    cz = longint'(mz) * 2 + longint'(uz);
    s = ux * ux + uy * uy + uz * uz;
    lim = longint'(root_floor(s) << 15);
    for (int i = 0; i < PLANES; i++) begin
      d = cx * longint'(nx_mem[i]) + cy * longint'(ny_mem[i]) +
          cz * longint'(nz_mem[i]) + longint'(off_mem[i]) * 65536;
      if (d >= lim) return 1'b0;
    end
    return 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (visible_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual %0b",
                 $time, out_visible);
        n_errors++;
      end else begin
        if (out_visible !== visible_q[0]) begin
          $display("%0t: visible mismatch: expected %0b, actual %0b",
                   $time, visible_q[0], out_visible);
          n_errors++;
        end
        void'(visible_q.pop_front());
      end
    end
  end

  // receiver: random stalls plus a long counted hold-off on request
  initial begin
    int hold_cnt;
    out_pop = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_cnt == 0) hold_cnt = 400;
      if (hold_cnt > 0) begin
        hold_cnt--;
        if (hold_cnt == 0) hold_req = 0;
        out_pop = 0;
      end else begin
        out_pop = !(recv_stall && $urandom_range(0, 99) < 57);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_MAX) begin
      $display("watchdog expired at %0t", $time);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_beat(logic rt, logic [2:0] idx, logic signed [15:0] nx, ny, nz,
                           logic signed [31:0] off, mx, my, mz,
                           logic [30:0] ex, ey, ez);
    while (send_mode && $urandom_range(0, 99) < 57) begin
      in_push = 0;
      @(negedge clk);
    end
    in_push = 1;
    in_req_type = rt; in_plane_index = idx;
    in_normal_x = nx; in_normal_y = ny; in_normal_z = nz; in_plane_offset = off;
    in_box_min_x = mx; in_box_min_y = my; in_box_min_z = mz;
    in_box_ext_x = ex; in_box_ext_y = ey; in_box_ext_z = ez;
    do @(posedge clk); while (in_full);
    if (rt == ReqLoad) begin
      n_loads++;
      if (idx < PLANES) begin
        nx_mem[idx] = nx; ny_mem[idx] = ny; nz_mem[idx] = nz; off_mem[idx] = off;
      end
    end else begin
      n_tests++;
      visible_q.push_back(box_visible(mx, my, mz, ex, ey, ez));
      if (!visible_q[$]) n_culled++;
    end
    @(negedge clk);
    in_push = 0;
  endtask

  // wait out every expected result, then let the pipeline settle
  task automatic drain();
    while (visible_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    logic signed [31:0] v;
    v = $signed($urandom) >>> $urandom_range(0, 31);
    return v;
  endfunction

  function automatic logic [30:0] rand_ext();
    return 31'($urandom >> $urandom_range(1, 31));
  endfunction

  task automatic load_plane(logic [2:0] idx, logic signed [15:0] nx, ny, nz,
                            logic signed [31:0] off);
    send_beat(ReqLoad, idx, nx, ny, nz, off, $urandom, $urandom, $urandom,
              31'($urandom), 31'($urandom), 31'($urandom));
  endtask

  task automatic test_box(logic signed [31:0] mx, my, mz, logic [30:0] ex, ey, ez);
    send_beat(ReqTest, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              $urandom, mx, my, mz, ex, ey, ez);
  endtask

  task automatic load_random_planes();
    for (int i = 0; i < PLANES; i++)
      load_plane(3'(i), 16'($urandom), 16'($urandom), 16'($urandom), rand_coord());
  endtask

  task automatic test_cleared_planes();
    // zero planes cull only a point box
    test_box(0, 0, 0, 0, 0, 0);
    test_box(32'h7fffffff, 32'h80000000, 5, 0, 0, 0);
    test_box(0, 0, 0, 1, 0, 0);
    test_box(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
             31'h7fffffff);
    drain();
  endtask

  task automatic test_extremes();
    load_plane(0, 16'sh7fff, 0, 0, 32'sh7fffffff);
    load_plane(1, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000);
    load_plane(2, 0, 16'sh7fff, 0, 0);
    load_plane(3, 0, 0, 16'sh8000, -32'sd65536);
    load_plane(4, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh80000000);
    load_plane(5, 0, 0, 0, -1);
    // out-of-range indexes must be dropped
    load_plane(6, 16'sh7fff, 0, 0, 32'sh7fffffff);
    load_plane(7, 16'sh7fff, 0, 0, 32'sh7fffffff);
    test_box(0, 0, 0, 0, 0, 0);
    test_box(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    test_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff,
             31'h7fffffff);
    test_box(32'sh80000000, 0, 32'sh7fffffff, 31'h7fffffff, 0, 31'h7fffffff);
    test_box(-65536, -65536, -65536, 131072, 131072, 131072);
    drain();
    load_plane(5, 16'sh8000, 0, 0, 32'sh80000000);
    test_box(-65536, -65536, -65536, 131072, 131072, 131072);
    test_box(32'sh7fffffff, 0, 0, 1, 1, 1);
    drain();
  endtask

  task automatic test_random(int items);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 9) == 0)
        load_plane(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                   16'($urandom), $urandom);
      else
        test_box(rand_coord(), rand_coord(), rand_coord(), rand_ext(), rand_ext(),
                 rand_ext());
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    for (int i = 0; i < 12; i++)
      test_box(rand_coord(), rand_coord(), rand_coord(), rand_ext(), rand_ext(),
               rand_ext());
    drain();
  endtask

  initial begin
    rst_n = 0; in_push = 0; in_req_type = ReqLoad; in_plane_index = 0;
    in_normal_x = 0; in_normal_y = 0; in_normal_z = 0; in_plane_offset = 0;
    in_box_min_x = 0; in_box_min_y = 0; in_box_min_z = 0;
    in_box_ext_x = 0; in_box_ext_y = 0; in_box_ext_z = 0;
    send_mode = 0; recv_stall = 0; hold_req = 0;
    n_tests = 0; n_loads = 0; n_culled = 0; n_errors = 0; idle_cycles = 0;
    for (int i = 0; i < PLANES; i++) begin
      nx_mem[i] = 0; ny_mem[i] = 0; nz_mem[i] = 0; off_mem[i] = 0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    test_cleared_planes();
    test_extremes();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_mode = 0; recv_stall = 0; end
        1: begin send_mode = 1; recv_stall = 0; end
        2: begin send_mode = 0; recv_stall = 1; end
        default: begin send_mode = 1; recv_stall = 1; end
      endcase
      load_random_planes();
      test_random(70);
    end
    send_mode = 0; recv_stall = 0;
    test_backpressure();
    drain();
    $display("covered %0d box tests (%0d culled) and %0d plane loads", n_tests,
             n_culled, n_loads);
    $display("idle phases on both sides, a long result hold-off and extreme planes");
    if (n_errors == 0 && visible_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/sfc_pkg.sv
rtl/sfc_front.sv
rtl/sfc_queue.sv
rtl/sfc_back.sv
rtl/sphere_frustum_cull_core.sv
sim/testbench.sv
